/* hw/rtl/fape_pkg.sv */
// Package with the shared types and command codes of the flash array model.
`default_nettype none

package fape_pkg;

  localparam int ADDR_W = 14;
  localparam int WORD_W = 32;

  typedef logic [1:0]        command_t;
  typedef logic [ADDR_W-1:0] addr_in_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam command_t CMD_READ       = 2'd0;
  localparam command_t CMD_PROGRAM    = 2'd1;
  localparam command_t CMD_ERASE_PROG = 2'd2;
  localparam command_t CMD_ERASE      = 2'd3;

  localparam word_t RESET_WORD = 32'hA5A5_A5A5;
  localparam word_t ONES_WORD  = 32'hFFFF_FFFF;
  localparam word_t ZERO_WORD  = 32'h0000_0000;

endpackage

`default_nettype wire

/* hw/rtl/fape_if.sv */
// Interfaces for the command, response and configuration channels of the flash array model.
`default_nettype none

interface fape_cmd_if;
  logic               valid;
  logic               ready;
  fape_pkg::command_t command;
  fape_pkg::addr_in_t word_address;
  fape_pkg::word_t    write_data;

  modport source (output valid, output command, output word_address, output write_data,
                  input ready);
  modport sink (input valid, input command, input word_address, input write_data,
                output ready);
endinterface

interface fape_rsp_if;
  logic            valid;
  logic            ready;
  fape_pkg::word_t read_data;
  logic            program_error;

  modport source (output valid, output read_data, output program_error, input ready);
  modport sink (input valid, input read_data, input program_error, output ready);
endinterface

interface fape_cfg_if;
  logic valid;
  logic ready;
  logic erased_level_ones;

  modport source (output valid, output erased_level_ones, input ready);
  modport sink (input valid, input erased_level_ones, output ready);
endinterface

`default_nettype wire

/* hw/rtl/flash_array_program_erase_model.sv */
// Top level of the word-addressed flash array model with program and page erase.
//
// The cmd channel takes one word per command: read, program, erase the page
// and then program when the address is the first word of its page, or erase
// the page. Each command yields exactly one word on the rsp channel, carrying
// the stored word at the address afterwards and a program error flag. The cfg
// channel sets the erased level and is always ready; the user must see that it is
// written only while the block is idle, which the block itself does not enforce.
// The array lives in one synchronous memory with a registered read port.
// A read or program goes through the memory read step and then the modify and
// write-back step, which loads the response register; the block takes no new
// command until it is back in idle. Commands that touch a page find the page
// base with a reciprocal multiplication in the divide and base steps. An erase
// then writes one word per cycle, holding at the last word until the response
// register frees, and then loads the response; an erase-and-program off a page
// boundary goes on to the read and modify steps. After reset the block fills
// every word of the array with the reset pattern and accepts no command
// meanwhile. A new command is accepted while a response waits; when the
// receiver stalls, the block holds its last step until the response register
// frees.
`default_nettype none

module flash_array_program_erase_model #(
  parameter int WORD_COUNT = 16384,
  parameter int PAGE_WORDS = 256
) (
  input wire logic clk,
  input wire logic rst,
  fape_cmd_if.sink cmd,
  fape_rsp_if.source rsp,
  fape_cfg_if.sink cfg
);

  import fape_pkg::*;

  localparam int MEM_AW = $clog2(WORD_COUNT);
  localparam int WQ_W   = $clog2((16383 / WORD_COUNT) + 1);
  localparam int PC_W   = $clog2(PAGE_WORDS + 1);
  localparam int RCP_W  = MEM_AW + 2;
  localparam int PRD_W  = MEM_AW + RCP_W;
  localparam int PG_SH  = MEM_AW + $clog2(PAGE_WORDS);
  localparam int BASE_W = MEM_AW + PC_W;
  localparam longint RCP_VAL =
    ((longint'(1) << PG_SH) + longint'(PAGE_WORDS) - longint'(1)) / longint'(PAGE_WORDS);
  localparam logic [RCP_W-1:0] PG_RECIP = RCP_W'(RCP_VAL);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_ERASE = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_MOD   = 3'd5;
  localparam logic [2:0] S_BASE  = 3'd6;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic              erased_ones;
  command_t          op;
  logic [MEM_AW-1:0] addr_q;
  word_t             data_q;
  logic [MEM_AW-1:0] page_q;
  logic [MEM_AW-1:0] ptr;
  logic [PC_W-1:0]   cnt;
  word_t             rdata;
  logic              out_valid_q;
  word_t             out_data;
  logic              out_err;

  word_t             mem [WORD_COUNT];
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  word_t             mem_wdata;

  addr_in_t          addr_red;
  logic [MEM_AW-1:0] addr_in_mem;
  logic [PRD_W-1:0]  pg_prod;
  logic [BASE_W-1:0] base_prod;
  logic [MEM_AW-1:0] page_base;
  logic              out_free;
  logic              out_load;
  word_t             out_data_next;
  logic              out_err_next;
  word_t             erased_word;
  word_t             prog_word;
  logic              clear_last;
  logic              erase_last;
  logic              accept;

  assign accept      = cmd.valid && cmd.ready;
  assign cmd.ready   = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign rsp.valid   = out_valid_q;
  assign rsp.read_data     = out_data;
  assign rsp.program_error = out_err;

  assign out_free    = !out_valid_q || rsp.ready;
  assign erased_word = erased_ones ? ONES_WORD : ZERO_WORD;
  assign prog_word   = erased_ones ? (rdata & data_q) : (rdata | data_q);
  assign clear_last  = (ptr == MEM_AW'(WORD_COUNT - 1));
  assign erase_last  = (cnt == PC_W'(PAGE_WORDS - 1)) || (ptr == MEM_AW'(WORD_COUNT - 1));

  always_comb begin
    addr_red = cmd.word_address;
    for (int k = WQ_W - 1; k >= 0; k--) begin
      if (addr_red >= ADDR_W'(WORD_COUNT << k)) begin
        addr_red = addr_red - ADDR_W'(WORD_COUNT << k);
      end
    end
  end

  assign addr_in_mem = MEM_AW'(addr_red);

  assign pg_prod   = PRD_W'(addr_q) * PRD_W'(PG_RECIP);
  assign base_prod = BASE_W'(page_q) * BASE_W'(PAGE_WORDS);
  assign page_base = base_prod[MEM_AW-1:0];

  always_comb begin
    state_next    = state;
    mem_we        = 1'b0;
    mem_waddr     = ptr;
    mem_wdata     = erased_word;
    out_load      = 1'b0;
    out_data_next = erased_word;
    out_err_next  = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_WORD;
        if (clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (cmd.command == CMD_READ || cmd.command == CMD_PROGRAM) begin
            state_next = S_READ;
          end else begin
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        state_next = S_BASE;
      end
      S_BASE: begin
        if (op == CMD_ERASE || addr_q == page_base) begin
          state_next = S_ERASE;
        end else begin
          state_next = S_READ;
        end
      end
      S_ERASE: begin
        mem_wdata = (op == CMD_ERASE_PROG && ptr == addr_q) ? data_q : erased_word;
        if (!erase_last || out_free) begin
          mem_we = 1'b1;
        end
        if (erase_last && out_free) begin
          out_load      = 1'b1;
          out_data_next = (op == CMD_ERASE_PROG) ? data_q : erased_word;
          state_next    = S_IDLE;
        end
      end
      S_READ: begin
        state_next = S_MOD;
      end
      S_MOD: begin
        mem_waddr = addr_q;
        mem_wdata = prog_word;
        if (out_free) begin
          out_load = 1'b1;
          if (op == CMD_READ) begin
            out_data_next = rdata;
          end else begin
            mem_we        = 1'b1;
            out_data_next = prog_word;
            out_err_next  = (prog_word != data_q);
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[addr_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      ptr         <= '0;
      cnt         <= '0;
      erased_ones <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        erased_ones <= cfg.erased_level_ones;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          ptr <= ptr + MEM_AW'(1);
        end
        S_BASE: begin
          ptr <= page_base;
          cnt <= '0;
        end
        S_ERASE: begin
          if (!erase_last) begin
            ptr <= ptr + MEM_AW'(1);
            cnt <= cnt + PC_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= cmd.command;
      addr_q <= addr_in_mem;
      data_q <= cmd.write_data;
    end else if (state == S_DIV) begin
      page_q <= MEM_AW'(pg_prod >> PG_SH);
    end
    if (out_load) begin
      out_data <= out_data_next;
      out_err  <= out_err_next;
    end
  end

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid_q) |-> ($past(state) == S_MOD || $past(state) == S_ERASE))
    else $error("Response raised outside a finishing step.");

  a_erase_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ERASE |-> ({1'b0, ptr} < (MEM_AW + 1)'(WORD_COUNT)))
    else $error("Erase pointer beyond the array.");

  a_erase_error: assert property (@(posedge clk) disable iff (rst)
    (state == S_ERASE && out_load) |=> (out_valid_q && !out_err))
    else $error("Erase response carries a program error.");

  a_div_step: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |=> state == S_BASE)
    else $error("Page base step skipped.");

endmodule

`default_nettype wire

/* tb/fape_checker.sv */
// Checker that mirrors the flash array, predicts every response word and compares it.
module fape_checker #(
  parameter int WORD_COUNT = 16384,
  parameter int PAGE_WORDS = 256
) (
  input  logic clk,
  input  logic rst,
  fape_cmd_if  cmd,
  fape_rsp_if  rsp,
  fape_cfg_if  cfg,
  output int   flash_fails,
  output int   words_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fape_pkg::*;

  typedef struct packed {
    word_t read_data;
    logic  program_error;
  } flash_reply_t;

  word_t        shadow_array [WORD_COUNT];
  logic         erased_ones;
  flash_reply_t reply_queue [$];
  int           fail_total;

  function automatic word_t erased_pattern();
    return erased_ones ? ONES_WORD : ZERO_WORD;
  endfunction

  function automatic void wipe_page(int unsigned addr);
    int unsigned base;
    base = addr - (addr % PAGE_WORDS);
    for (int unsigned i = 0; i < PAGE_WORDS; i++) begin
      if (base + i >= WORD_COUNT) break;
      shadow_array[base + i] = erased_pattern();
    end
  endfunction

  function automatic logic burn_word(int unsigned addr, word_t data);
    if (erased_ones) begin
      shadow_array[addr] = shadow_array[addr] & data;
    end else begin
      shadow_array[addr] = shadow_array[addr] | data;
    end
    return (shadow_array[addr] != data);
  endfunction

  function automatic flash_reply_t apply_command(command_t op, addr_in_t waddr, word_t data);
    flash_reply_t reply;
    int unsigned  addr;
    logic         err;
    addr = int'(waddr) % WORD_COUNT;
    err  = 1'b0;
    case (op)
      CMD_PROGRAM: begin
        err = burn_word(addr, data);
      end
      CMD_ERASE_PROG: begin
        if (addr % PAGE_WORDS == 0) wipe_page(addr);
        err = burn_word(addr, data);
      end
      CMD_ERASE: begin
        wipe_page(addr);
      end
      default: begin
      end
    endcase
    reply.read_data     = shadow_array[addr];
    reply.program_error = err;
    return reply;
  endfunction

  always @(posedge clk) begin
    flash_reply_t want;
    if (rst) begin
      foreach (shadow_array[i]) shadow_array[i] = RESET_WORD;
      erased_ones = 1'b1;
      reply_queue.delete();
      fail_total = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (reply_queue.size() == 0) begin
          fail_total++;
          if (fail_total <= 10) begin
            $display("%0t: response word with none expected: read_data %h program_error %b",
                     $realtime, rsp.read_data, rsp.program_error);
          end
        end else begin
          want = reply_queue.pop_front();
          if (rsp.read_data !== want.read_data || rsp.program_error !== want.program_error) begin
            fail_total++;
            if (fail_total <= 10) begin
              $display("%0t: response word mismatch: read_data exp %h got %h, %s exp %b got %b",
                       $realtime, want.read_data, rsp.read_data, "program_error",
                       want.program_error, rsp.program_error);
            end
          end
        end
      end
      if (cfg.valid && cfg.ready) erased_ones = cfg.erased_level_ones;
      if (cmd.valid && cmd.ready) begin
        reply_queue.push_back(apply_command(cmd.command, cmd.word_address, cmd.write_data));
      end
    end
    flash_fails   <= fail_total;
    words_pending <= reply_queue.size();
  end

endmodule

/* tb/tb_flash_array_program_erase_model.sv */
// Testbench top for the flash array model: drives commands, configuration and stalls, and gives the verdict.
module tb_flash_array_program_erase_model;
  timeunit 1ns;
  timeprecision 1ps;
  import fape_pkg::*;

  logic clk = 1'b0;
  logic rst;
  int   flash_fails;
  int   words_pending;
  int   items_sent = 0;
  bit   sender_idle = 1'b1;
  bit   receiver_idle = 1'b1;
  bit   long_hold_armed = 1'b0;

  fape_cmd_if cmd_ch ();
  fape_rsp_if rsp_ch ();
  fape_cfg_if cfg_ch ();

  flash_array_program_erase_model #(
    .WORD_COUNT(16384),
    .PAGE_WORDS(256)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  fape_checker #(
    .WORD_COUNT(16384),
    .PAGE_WORDS(256)
  ) flash_check (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch),
    .flash_fails(flash_fails),
    .words_pending(words_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int stall;
    int hold;
    stall = 0;
    hold  = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_armed) begin
        long_hold_armed = 1'b0;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        rsp_ch.ready <= 1'b0;
      end else if (receiver_idle && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 18) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  function automatic word_t pick_word();
    case ($urandom_range(0, 5))
      0: return ZERO_WORD;
      1: return ONES_WORD;
      2: return $urandom & $urandom;
      3: return $urandom | $urandom;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_cmd(command_t op, addr_in_t addr, word_t data);
    if (sender_idle && $urandom_range(0, 5) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.command      <= op;
    cmd_ch.word_address <= addr;
    cmd_ch.write_data   <= data;
    do @(posedge clk); while (!cmd_ch.ready);
    items_sent++;
  endtask

  task automatic drain_words();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  task automatic write_erased_level(logic level);
    drain_words();
    repeat (4) @(posedge clk);
    cfg_ch.valid             <= 1'b1;
    cfg_ch.erased_level_ones <= level;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic page_burst();
    int unsigned page;
    addr_in_t    base;
    addr_in_t    addr;
    word_t       data;
    page = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
    base = addr_in_t'(page * 256);
    if ($urandom_range(0, 1) == 1) begin
      push_cmd(CMD_ERASE, base | addr_in_t'($urandom_range(0, 255)), $urandom);
    end else begin
      push_cmd(CMD_ERASE_PROG, base, pick_word());
    end
    repeat ($urandom_range(2, 10)) begin
      if ($urandom_range(0, 3) == 0) begin
        addr = base | addr_in_t'($urandom_range(0, 255));
      end else begin
        addr = base | addr_in_t'($urandom_range(0, 15));
      end
      data = pick_word();
      case ($urandom_range(0, 5))
        0, 1: push_cmd(CMD_PROGRAM, addr, data);
        2: push_cmd(CMD_READ, addr, $urandom);
        3: begin
          push_cmd(CMD_PROGRAM, addr, data);
          push_cmd(CMD_READ, addr, $urandom);
        end
        4: push_cmd(CMD_ERASE_PROG, addr, data);
        default: begin
          push_cmd(CMD_PROGRAM, addr, data);
          push_cmd(CMD_PROGRAM, addr, pick_word());
        end
      endcase
    end
  endtask

  initial begin
    int phase_end;
    int guard;
    rst                      <= 1'b1;
    cmd_ch.valid             <= 1'b0;
    cmd_ch.command           <= CMD_READ;
    cmd_ch.word_address      <= '0;
    cmd_ch.write_data        <= '0;
    cfg_ch.valid             <= 1'b0;
    cfg_ch.erased_level_ones <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    push_cmd(CMD_READ, 14'h0000, ZERO_WORD);
    push_cmd(CMD_READ, 14'h3FFF, ONES_WORD);
    push_cmd(CMD_PROGRAM, 14'h0005, 32'hFFFF_0000);
    push_cmd(CMD_ERASE, 14'h3FFF, ONES_WORD);
    push_cmd(CMD_READ, 14'h3F00, ZERO_WORD);
    push_cmd(CMD_PROGRAM, 14'h3FFF, ZERO_WORD);
    push_cmd(CMD_PROGRAM, 14'h3FFF, ONES_WORD);
    push_cmd(CMD_ERASE_PROG, 14'h0100, 32'h1234_5678);
    push_cmd(CMD_ERASE_PROG, 14'h0101, ONES_WORD);
    push_cmd(CMD_ERASE, 14'h0180, 32'h5555_AAAA);
    push_cmd(CMD_READ, 14'h0100, ZERO_WORD);
    push_cmd(CMD_PROGRAM, 14'h0100, 32'hAAAA_AAAA);
    push_cmd(CMD_PROGRAM, 14'h0100, 32'h5555_5555);
    push_cmd(CMD_READ, 14'h2AAA, ONES_WORD);
    push_cmd(CMD_ERASE, 14'h1555, ONES_WORD);

    write_erased_level(1'b0);
    push_cmd(CMD_ERASE, 14'h0200, ZERO_WORD);
    push_cmd(CMD_PROGRAM, 14'h0200, ONES_WORD);
    push_cmd(CMD_PROGRAM, 14'h0201, ZERO_WORD);
    push_cmd(CMD_PROGRAM, 14'h0202, 32'h0F0F_0F0F);
    push_cmd(CMD_PROGRAM, 14'h0202, 32'hF0F0_F0F0);
    push_cmd(CMD_ERASE_PROG, 14'h0300, 32'hDEAD_BEEF);
    push_cmd(CMD_ERASE_PROG, 14'h0301, 32'h0000_00FF);
    push_cmd(CMD_PROGRAM, 14'h0000, 32'h5A5A_5A5A);
    push_cmd(CMD_READ, 14'h3FFF, ZERO_WORD);

    for (int phase = 0; phase < 6; phase++) begin
      write_erased_level((phase % 2 == 0) ? 1'b1 : 1'b0);
      sender_idle   = (phase != 2) && (phase != 5);
      receiver_idle = (phase != 3) && (phase != 5);
      if (phase == 1) long_hold_armed = 1'b1;
      phase_end = items_sent + 172;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 3) == 0) begin
          push_cmd(command_t'($urandom_range(0, 3)), addr_in_t'($urandom_range(0, 16383)),
                   pick_word());
        end else begin
          page_burst();
        end
      end
    end

    cmd_ch.valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (words_pending != 0 && guard < 20000);
    repeat (20) @(posedge clk);
    if (flash_fails == 0 && words_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
